// File: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	localparam int DATA_W = 64;
	localparam int DEN_W  = 32;
	localparam int SIDE_W = 34;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] CFG_TEMP    = 2'd0;
	localparam logic [IDX_W-1:0] CFG_PRESS_A = 2'd1;
	localparam logic [IDX_W-1:0] CFG_PRESS_B = 2'd2;
	localparam logic [IDX_W-1:0] CFG_PRESS_C = 2'd3;

	localparam logic signed [25:0] FINE_BIAS = 26'sd128000;
	localparam logic signed [63:0] DIV_SCALE = 64'sd3125;
	localparam logic signed [63:0] DEN_BIAS  = 64'sh0000_8000_0000_0000;
	localparam logic [20:0]        RAW_FULL  = 21'h100000;

endpackage

`default_nettype wire

// File: rtl/ptc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ptc_div #(
	parameter int DW = ptc_pkg::DATA_W,
	parameter int RW = ptc_pkg::DEN_W,
	parameter int SW = ptc_pkg::SIDE_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [DW-1:0] num,
	input  wire logic [RW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_vld,
	output logic [DW-1:0]      quot,
	output logic [SW-1:0]      out_side
);

	logic          vld_s  [1:DW];
	logic [RW-1:0] rem_s  [1:DW];
	logic [DW-1:0] nq_s   [1:DW];
	logic [RW-1:0] den_s  [1:DW];
	logic [SW-1:0] side_s [1:DW];

	// one quotient bit per stage, restoring
	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic          vld_in;
		logic [RW-1:0] rem_in;
		logic [DW-1:0] nq_in;
		logic [RW-1:0] den_in;
		logic [SW-1:0] side_in;
		logic [RW-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_head
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign nq_in   = num;
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_body
			assign vld_in  = vld_s[i];
			assign rem_in  = rem_s[i];
			assign nq_in   = nq_s[i];
			assign den_in  = den_s[i];
			assign side_in = side_s[i];
		end

		assign trial = {rem_in[RW-2:0], nq_in[DW-1]};
		assign ge    = trial >= den_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? (trial - den_in) : trial;
				nq_s[i+1]   <= {nq_in[DW-2:0], ge};
				den_s[i+1]  <= den_in;
				side_s[i+1] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[DW];
	assign quot     = nq_s[DW];
	assign out_side = side_s[DW];

endmodule

`default_nettype wire

// File: rtl/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                  | direction
// in      | in_valid, in_stall, raw_temp, raw_press  | item in
// out     | out_valid, out_stall, temp_centi,        | item out
//         | press_q24_8, press_valid                 |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// One item per cycle unless the output stalls; 11 arithmetic stages, 64 stages of
// the bit-per-stage divider, 5 arithmetic stages ending in the output register.
// Reset clears all stage valid bits and the calibration registers.
// A stall on a valid output holds the whole pipeline and stalls the input.

module pressure_temperature_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [19:0] raw_temp,
	input  wire logic [19:0] raw_press,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      temp_centi,
	output logic [31:0]      press_q24_8,
	output logic             press_valid,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [47:0] temp_calib_q;
	logic [63:0] press_calib_a_q;
	logic [63:0] press_calib_b_q;
	logic [15:0] press_calib_c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q    <= '0;
			press_calib_a_q <= '0;
			press_calib_b_q <= '0;
			press_calib_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptc_pkg::CFG_TEMP:    temp_calib_q    <= cfg_data[47:0];
				ptc_pkg::CFG_PRESS_A: press_calib_a_q <= cfg_data;
				ptc_pkg::CFG_PRESS_B: press_calib_b_q <= cfg_data;
				ptc_pkg::CFG_PRESS_C: press_calib_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_calib_q[15:0];
	assign t2 = $signed(temp_calib_q[31:16]);
	assign t3 = $signed(temp_calib_q[47:32]);
	assign p1 = press_calib_a_q[15:0];
	assign p2 = $signed(press_calib_a_q[31:16]);
	assign p3 = $signed(press_calib_a_q[47:32]);
	assign p4 = $signed(press_calib_a_q[63:48]);
	assign p5 = $signed(press_calib_b_q[15:0]);
	assign p6 = $signed(press_calib_b_q[31:16]);
	assign p7 = $signed(press_calib_b_q[47:32]);
	assign p8 = $signed(press_calib_b_q[63:48]);
	assign p9 = $signed(press_calib_c_q);

	logic en;
	logic vld_s16;

	assign en       = !(vld_s16 && out_stall);
	assign in_stall = !en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	logic div_vld;

	logic signed [17:0] tx_s1;
	logic signed [16:0] td_s1;
	logic [20:0]        pr_s1;
	logic signed [33:0] ta_s2, dd_s2;
	logic [20:0]        pr_s2;
	logic signed [22:0] ta_s3;
	logic signed [37:0] tb_s3;
	logic [20:0]        pr_s3;
	logic signed [31:0] fine_s4;
	logic [20:0]        pr_s4;
	logic signed [31:0] temp_s5;
	logic signed [25:0] pa_s5;
	logic [20:0]        pr_s5;
	logic signed [31:0] temp_s6;
	logic signed [51:0] aa_s6;
	logic signed [41:0] ap5_s6, ap2_s6;
	logic [20:0]        pr_s6;
	logic signed [31:0] temp_s7;
	logic signed [63:0] b1_s7, a1_s7;
	logic signed [41:0] ap5_s7, ap2_s7;
	logic [20:0]        pr_s7;
	logic signed [31:0] temp_s8;
	logic signed [63:0] b_s8, a2_s8;
	logic [20:0]        pr_s8;
	logic signed [31:0] temp_s9;
	logic signed [63:0] dp_s9, num0_s9;
	logic signed [31:0] temp_s10;
	logic signed [30:0] den_s10;
	logic signed [63:0] num_s10;
	logic [31:0]        temp_s11;
	logic [63:0]        ma_s11;
	logic [31:0]        mb_s11;
	logic               neg_s11, zero_s11;

	logic signed [34:0] temp_n;
	logic signed [67:0] b1_n, a1_n;
	logic signed [63:0] x_n;
	logic signed [80:0] dp_n;
	logic signed [63:0] num_n;

	assign temp_n = 35'(fine_s4) * 35'sd5 + 35'sd128;
	assign b1_n   = aa_s6 * p6;
	assign a1_n   = aa_s6 * p3;
	assign x_n    = a2_s8 + ptc_pkg::DEN_BIAS;
	assign dp_n   = x_n * $signed({1'b0, p1});
	assign num_n  = num0_s9 * ptc_pkg::DIV_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1 <= $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
			td_s1 <= $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, t1});
			pr_s1 <= ptc_pkg::RAW_FULL - {1'b0, raw_press};

			ta_s2 <= tx_s1 * t2;
			dd_s2 <= td_s1 * td_s1;
			pr_s2 <= pr_s1;

			ta_s3 <= 23'(ta_s2 >>> 11);
			tb_s3 <= 22'(dd_s2 >>> 12) * t3;
			pr_s3 <= pr_s2;

			fine_s4 <= 32'(ta_s3) + 32'(tb_s3 >>> 14);
			pr_s4   <= pr_s3;

			temp_s5 <= 32'(temp_n >>> 8);
			pa_s5   <= fine_s4[25:0] - ptc_pkg::FINE_BIAS;
			pr_s5   <= pr_s4;

			temp_s6 <= temp_s5;
			aa_s6   <= pa_s5 * pa_s5;
			ap5_s6  <= pa_s5 * p5;
			ap2_s6  <= pa_s5 * p2;
			pr_s6   <= pr_s5;

			temp_s7 <= temp_s6;
			b1_s7   <= b1_n[63:0];
			a1_s7   <= a1_n[63:0];
			ap5_s7  <= ap5_s6;
			ap2_s7  <= ap2_s6;
			pr_s7   <= pr_s6;

			temp_s8 <= temp_s7;
			b_s8    <= b1_s7 + (64'(ap5_s7) <<< 17) + (64'(p4) <<< 35);
			a2_s8   <= (a1_s7 >>> 8) + (64'(ap2_s7) <<< 12);
			pr_s8   <= pr_s7;

			temp_s9 <= temp_s8;
			dp_s9   <= dp_n[63:0];
			num0_s9 <= $signed({12'b0, pr_s8, 31'b0}) - b_s8;

			temp_s10 <= temp_s9;
			den_s10  <= dp_s9[63:33];
			num_s10  <= num_n;

			temp_s11 <= temp_s10;
			zero_s11 <= den_s10 == '0;
			neg_s11  <= num_s10[63] ^ den_s10[30];
			ma_s11   <= num_s10[63] ? 64'(-num_s10) : 64'(num_s10);
			mb_s11   <= {1'b0, den_s10[30] ? 31'(-den_s10) : 31'(den_s10)};
		end
	end

	logic [63:0] quot;
	logic [33:0] div_side;

	ptc_div #(
		.DW(ptc_pkg::DATA_W),
		.RW(ptc_pkg::DEN_W),
		.SW(ptc_pkg::SIDE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s11),
		.num     (ma_s11),
		.den     (mb_s11),
		.side    ({temp_s11, neg_s11, zero_s11}),
		.out_vld (div_vld),
		.quot    (quot),
		.out_side(div_side)
	);

	logic [31:0]        temp_s12, temp_s13, temp_s14, temp_s15, temp_s16;
	logic               zero_s12, zero_s13, zero_s14, zero_s15;
	logic signed [63:0] pq_s12, pq_s13, pq_s14, pq_s15;
	logic [63:0]        mll_s13;
	logic [30:0]        mlh_s13;
	logic signed [63:0] p8p_s13;
	logic [63:0]        sq_s14;
	logic signed [63:0] pb_s14, pb_s15, s9_s15;
	logic [31:0]        press_s16;
	logic               pv_s16;

	logic signed [50:0] d_n;
	logic signed [51:0] mlh_n;
	logic signed [79:0] p8p_n, s9_n;
	logic signed [63:0] sum_n, res_n;

	assign d_n   = 51'(pq_s12 >>> 13);
	assign mlh_n = $signed({1'b0, d_n[31:0]}) * $signed(d_n[50:32]);
	assign p8p_n = pq_s12 * p8;
	assign s9_n  = $signed(sq_s14) * p9;
	assign sum_n = pq_s15 + (s9_s15 >>> 25) + pb_s15;
	assign res_n = (sum_n >>> 8) + (64'(p7) <<< 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else if (en) begin
			vld_s12 <= div_vld;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s12 <= div_side[33:2];
			zero_s12 <= div_side[0];
			pq_s12   <= div_side[1] ? $signed(-quot) : $signed(quot);

			temp_s13 <= temp_s12;
			zero_s13 <= zero_s12;
			pq_s13   <= pq_s12;
			mll_s13  <= d_n[31:0] * d_n[31:0];
			mlh_s13  <= mlh_n[30:0];
			p8p_s13  <= p8p_n[63:0];

			temp_s14 <= temp_s13;
			zero_s14 <= zero_s13;
			pq_s14   <= pq_s13;
			sq_s14   <= mll_s13 + {mlh_s13, 33'b0};
			pb_s14   <= p8p_s13 >>> 19;

			temp_s15 <= temp_s14;
			zero_s15 <= zero_s14;
			pq_s15   <= pq_s14;
			pb_s15   <= pb_s14;
			s9_s15   <= s9_n[63:0];

			temp_s16  <= temp_s15;
			pv_s16    <= !zero_s15;
			press_s16 <= zero_s15 ? '0 : res_n[31:0];
		end
	end

	assign out_valid   = vld_s16;
	assign temp_centi  = temp_s16;
	assign press_q24_8 = press_s16;
	assign press_valid = pv_s16;

endmodule

`default_nettype wire

// File: tb/sv/pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps

module pressure_temperature_compensation_tb;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
	} sample_t;

	typedef struct packed {
		logic [31:0] temp_centi;
		logic [31:0] press_q24_8;
		logic        press_valid;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [19:0] raw_temp;
	logic [19:0] raw_press;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] temp_centi;
	logic [31:0] press_q24_8;
	logic        press_valid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	pressure_temperature_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_temp(raw_temp), .raw_press(raw_press),
		.out_valid(out_valid), .out_stall(out_stall),
		.temp_centi(temp_centi), .press_q24_8(press_q24_8), .press_valid(press_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_press_c;

	sample_t  pending_samples[$];
	reading_t expected_readings[$];
	int       errors;
	bit       hold_output;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic signed [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic signed [63:0] quot(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] q;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic reading_t compensate(input sample_t s);
		logic signed [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] a, b, d, fine, p;
		reading_t r;
		adc_t = {44'd0, s.raw_temp};
		adc_p = {44'd0, s.raw_press};
		t1 = {48'd0, cal_temp[15:0]};
		t2 = sx16(cal_temp[31:16]);
		t3 = sx16(cal_temp[47:32]);
		p1 = {48'd0, cal_press_a[15:0]};
		p2 = sx16(cal_press_a[31:16]);
		p3 = sx16(cal_press_a[47:32]);
		p4 = sx16(cal_press_a[63:48]);
		p5 = sx16(cal_press_b[15:0]);
		p6 = sx16(cal_press_b[31:16]);
		p7 = sx16(cal_press_b[47:32]);
		p8 = sx16(cal_press_b[63:48]);
		p9 = sx16(cal_press_c);
		a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		r.temp_centi = 32'((fine * 5 + 128) >>> 8);
		a = fine - 128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			r.press_q24_8 = '0;
			r.press_valid = 1'b0;
			return r;
		end
		p = 64'sd1048576 - adc_p;
		p = quot(((p <<< 31) - b) * 3125, a);
		d = p >>> 13;
		a = (p9 * d * d) >>> 25;
		b = (p8 * p) >>> 19;
		p = ((p + a + b) >>> 8) + (p7 <<< 4);
		r.press_q24_8 = p[31:0];
		r.press_valid = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			raw_temp <= '0;
			raw_press <= '0;
			send_gap = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid && !in_stall)
				void'(pending_samples.pop_front());
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				raw_temp <= pending_samples[0].raw_temp;
				raw_press <= pending_samples[0].raw_press;
				case ($urandom_range(0, 9))
					0, 1: send_gap = $urandom_range(1, 3);
					2: send_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : 0;
					default: send_gap = 0;
				endcase
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// prediction at acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_readings.push_back(compensate({raw_temp, raw_press}));
	end

	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (hold_output) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			case ($urandom_range(0, 15))
				0, 1: stall_left = $urandom_range(1, 3);
				2: stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : 0;
				default: stall_left = 0;
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report("unexpected item", temp_centi, 32'd0);
			end else begin
				want = expected_readings.pop_front();
				if (temp_centi !== want.temp_centi)
					report("temp_centi", temp_centi, want.temp_centi);
				if (press_q24_8 !== want.press_q24_8)
					report("press_q24_8", press_q24_8, want.press_q24_8);
				if (press_valid !== want.press_valid)
					report("press_valid", press_valid, want.press_valid);
			end
		end
	end

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ptc_pkg::CFG_TEMP: cal_temp = val[47:0];
			ptc_pkg::CFG_PRESS_A: cal_press_a = val;
			ptc_pkg::CFG_PRESS_B: cal_press_b = val;
			ptc_pkg::CFG_PRESS_C: cal_press_c = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic set_calibration(input int mode);
		case (mode)
			0: begin
				// typical factory coefficients
				write_reg(ptc_pkg::CFG_TEMP, {16'sd50, 16'sd26435, 16'd27504});
				write_reg(ptc_pkg::CFG_PRESS_A,
					{16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
				write_reg(ptc_pkg::CFG_PRESS_B, {-16'sd7, 16'sd15500, -16'sd14600, 16'sd140});
				write_reg(ptc_pkg::CFG_PRESS_C, 64'd6000);
			end
			1: begin
				write_reg(ptc_pkg::CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(ptc_pkg::CFG_PRESS_A, '1);
				write_reg(ptc_pkg::CFG_PRESS_B, '1);
				write_reg(ptc_pkg::CFG_PRESS_C, '1);
			end
			2: begin
				write_reg(ptc_pkg::CFG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
				write_reg(ptc_pkg::CFG_PRESS_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
				write_reg(ptc_pkg::CFG_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(ptc_pkg::CFG_PRESS_C, 64'h8000);
			end
			3: begin
				// P1 zero: divisor zero
				write_reg(ptc_pkg::CFG_PRESS_A, 64'h1234_5678_9ABC_0000);
			end
			default: begin
				write_reg(ptc_pkg::CFG_TEMP, rand64());
				write_reg(ptc_pkg::CFG_PRESS_A, rand64());
				write_reg(ptc_pkg::CFG_PRESS_B, rand64());
				write_reg(ptc_pkg::CFG_PRESS_C, rand64());
			end
		endcase
	endtask

	task automatic push_random(input int n);
		sample_t s;
		repeat (n) begin
			s.raw_temp = 20'(($urandom_range(0, 3) == 0) ? $urandom()
				: $urandom_range(400000, 600000));
			s.raw_press = 20'(($urandom_range(0, 3) == 0) ? $urandom()
				: $urandom_range(250000, 450000));
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		errors = 0;
		hold_output = 1'b0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: divisor zero
		pending_samples.push_back({20'd0, 20'd0});
		pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
		drain();

		set_calibration(0);
		pending_samples.push_back({20'd0, 20'd0});
		pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
		pending_samples.push_back({20'd519888, 20'd415148});
		pending_samples.push_back({20'hAAAAA, 20'h55555});
		pending_samples.push_back({20'h55555, 20'hAAAAA});
		pending_samples.push_back({20'd0, 20'hFFFFF});
		drain();
		set_calibration(1);
		pending_samples.push_back({20'hFFFFF, 20'd0});
		pending_samples.push_back({20'd0, 20'hFFFFF});
		push_random(4);
		drain();
		set_calibration(2);
		pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
		pending_samples.push_back({20'd0, 20'd0});
		push_random(4);
		drain();
		set_calibration(3);
		push_random(4);
		drain();

		// output held while input keeps offering
		set_calibration(0);
		hold_output = 1'b1;
		push_random(150);
		repeat (300) @(posedge clk);
		hold_output = 1'b0;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_calibration(ph == 0 ? 0 : (ph == 5 ? 1 : 4));
			push_random(100);
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
